/* rtl/core/bts7_pkg.sv */
// Shared types, widths and constants for the four-digit seven-segment encoder.
// Holds the glyph lookup and the reciprocal constants used for decimal splitting.
// No dependencies.
package bts7_pkg;

    localparam int NUM_W     = 16;
    localparam int DOT_W     = 3;
    localparam int DIGIT_W   = 4;
    localparam int SEG_W     = 8;
    localparam int N_DIGITS  = 4;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int PROD_W    = 33;

    // floor(v / d) == (v * RECIP) >> SHIFT, exact for any 16-bit v
    localparam logic [16:0] RECIP_10    = 17'd52429;
    localparam int          SHIFT_10    = 19;
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam int          SHIFT_100   = 23;
    localparam logic [16:0] RECIP_1000  = 17'd67109;
    localparam int          SHIFT_1000  = 26;
    localparam logic [16:0] RECIP_10000 = 17'd107375;
    localparam int          SHIFT_10000 = 30;

    localparam logic [SEG_W-1:0] DOT_BIT = 8'h80;

    typedef logic [N_DIGITS-1:0][DIGIT_W-1:0] t_digits;
    typedef logic [N_DIGITS-1:0][SEG_W-1:0]   t_segs;

    function automatic logic [SEG_W-1:0] f_glyph(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7C;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h67;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

/* rtl/core/bts7_digits.sv */
// Splits a 16-bit value into its four lowest decimal digits, units first.
// Each quotient comes straight from the value by a constant reciprocal multiply.
// Depends on bts7_pkg.
module bts7_digits
    import bts7_pkg::*;
(
    input  logic [NUM_W-1:0] i_value,
    output t_digits          o_digits
);

    logic [PROD_W-1:0] p10, p100, p1000, p10000;
    logic [NUM_W-1:0]  q10, q100, q1000, q10000;
    logic [NUM_W-1:0]  d0, d1, d2, d3;

    assign p10    = PROD_W'(i_value) * PROD_W'(RECIP_10);
    assign p100   = PROD_W'(i_value) * PROD_W'(RECIP_100);
    assign p1000  = PROD_W'(i_value) * PROD_W'(RECIP_1000);
    assign p10000 = PROD_W'(i_value) * PROD_W'(RECIP_10000);

    assign q10    = NUM_W'(p10    >> SHIFT_10);
    assign q100   = NUM_W'(p100   >> SHIFT_100);
    assign q1000  = NUM_W'(p1000  >> SHIFT_1000);
    assign q10000 = NUM_W'(p10000 >> SHIFT_10000);

    // x*10 as shift-add
    assign d0 = i_value - ((q10    << 3) + (q10    << 1));
    assign d1 = q10     - ((q100   << 3) + (q100   << 1));
    assign d2 = q100    - ((q1000  << 3) + (q1000  << 1));
    assign d3 = q1000   - ((q10000 << 3) + (q10000 << 1));

    assign o_digits[0] = d0[DIGIT_W-1:0];
    assign o_digits[1] = d1[DIGIT_W-1:0];
    assign o_digits[2] = d2[DIGIT_W-1:0];
    assign o_digits[3] = d3[DIGIT_W-1:0];

endmodule

/* rtl/core/bts7_encode.sv */
// Maps four decimal digits to segment bytes and places the decimal point.
// Depends on bts7_pkg.
module bts7_encode
    import bts7_pkg::*;
(
    input  t_digits          i_digits,
    input  logic [DOT_W-1:0] i_dot_position,
    output t_segs            o_segs
);

    always_comb begin
        for (int k = 0; k < N_DIGITS; k++) begin
            o_segs[k] = f_glyph(i_digits[k]);
            if (i_dot_position == DOT_W'(k + 1)) begin
                o_segs[k] = o_segs[k] | DOT_BIT;
            end
        end
    end

endmodule

/* rtl/core/binary_to_seven_segment_4digit.sv */
// Top level of the four-digit binary to seven-segment encoder.
// Input register, decimal split, glyph encode, output register.
// Depends on bts7_pkg, bts7_digits, bts7_encode.
//
// Slave channel (i_s_*): one word carries a 16-bit value and a 3-bit
// decimal-point position (1 = units .. 4 = thousands, other codes: no dot).
// Master channel (o_m_*): one word carries four segment bytes, units in the
// low byte, bit 7 of each byte is the decimal point, bits 6..0 are g..a.
// Only the value modulo 10000 is shown; leading zeros show as 0.
// Path: an accepted word is captured in the input register, split and encoded
// combinationally, and its segment bytes are then captured in the result
// register, which drives o_m_tvalid and o_m_tdata.
// Throughput: one word per cycle while i_m_tready is high; the decimal split uses
// four independent constant-reciprocal multiplies, so nothing iterates.
// Stall: while a result waits and i_m_tready is low, the result register holds and
// the input register fills; o_s_tready drops only once both hold a word.
// Reset: i_rst_n low (synchronous) empties both stages; no result is pending.
module binary_to_seven_segment_4digit
    import bts7_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // [15:0] number_value, [18:16] dot_position
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // seg_units, seg_tens, seg_hundreds, seg_thousands
);

    logic             r_in_valid, n_in_valid;
    logic [NUM_W-1:0] r_value, n_value;
    logic [DOT_W-1:0] r_dot, n_dot;
    logic             r_out_valid, n_out_valid;
    t_segs            r_segs, n_segs;

    logic    advance;
    t_digits digits;
    t_segs   segs;

    bts7_digits u_digits (
        .i_value  (r_value),
        .o_digits (digits)
    );

    bts7_encode u_encode (
        .i_digits       (digits),
        .i_dot_position (r_dot),
        .o_segs         (segs)
    );

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_value     = r_value;
        n_dot       = r_dot;
        n_out_valid = r_out_valid;
        n_segs      = r_segs;
        if (advance) begin
            n_out_valid = r_in_valid;
            n_segs      = segs;
        end
        if (o_s_tready) begin
            n_in_valid = i_s_tvalid;
            n_value    = i_s_tdata[NUM_W-1:0];
            n_dot      = i_s_tdata[NUM_W+DOT_W-1:NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_dot   <= n_dot;
        r_segs  <= n_segs;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_segs;

endmodule
